// ----- hw/rtl/duplicate_and_missing_finder_assert.svh -----
// Assertion macros for the duplicate and missing finder.
// Included by the RTL files that assert. No dependencies.
`ifndef DUPLICATE_AND_MISSING_FINDER_ASSERT_SVH
`define DUPLICATE_AND_MISSING_FINDER_ASSERT_SVH
`ifndef SYNTH
// Checked with reset as a disable condition.
`define DMF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define DMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DMF_ASSERT(lbl, clk, rstn, prop, msg)
`define DMF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/dmf_pkg.sv -----
// Package for the duplicate and missing finder: field widths, payload structs,
// and the command and status structs between controller and datapath. No dependencies.
package dmf_pkg;

    localparam int VAL_W         = 13;
    localparam int SUM_W         = 24;
    localparam int SQ_W          = 35;
    localparam int MAX_COUNT_DEF = 4096;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             is_last;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] repeating;
        logic [VAL_W-1:0] absent;
        logic             valid_res;
    } out_item_t;

    typedef struct packed {
        logic prod1;
        logic prod2;
        logic load_s2n;
        logic div_start;
        logic load_add;
        logic fix;
        logic clear;
    } dmf_cmd_t;

    typedef struct packed {
        logic div_done;
        logic diff_zero;
    } dmf_status_t;

endpackage

// ----- hw/rtl/dmf_divider.sv -----
// Signed divider, restoring, one quotient bit per cycle, truncation toward zero.
// Stand-alone; the datapath uses it to divide the square-sum difference by the sum difference.
module dmf_divider #(
    parameter int DW = 42
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic signed [DW-1:0] divisor,
    output logic                 done,
    output logic signed [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic          neg_reg, neg_next;

    logic [DW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [DW:0]   shifted;
    logic [DW:0]   trial;

    assign num_mag = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
    assign den_mag = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
    assign shifted = {rem_reg[DW-1:0], quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            rem_next  = '0;
            quo_next  = num_mag;
            den_next  = den_mag;
            neg_next  = dividend[DW-1] ^ divisor[DW-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DW])
            begin
                rem_next = trial;
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(-quo_reg) : $signed(quo_reg);

endmodule

// ----- hw/rtl/dmf_datapath.sv -----
// Datapath of the duplicate and missing finder: accumulators, closed-form sums,
// the divider and the result register. Depends on dmf_pkg and dmf_divider.
module dmf_datapath #(
    parameter int MAX_COUNT = dmf_pkg::MAX_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  dmf_pkg::in_item_t    item,
    input  dmf_pkg::dmf_cmd_t    cmd,
    output dmf_pkg::dmf_status_t status,
    output dmf_pkg::out_item_t   result
);
    import dmf_pkg::*;

    localparam int NW  = $clog2(MAX_COUNT + 1);
    localparam int P1W = 2 * NW + 1;
    localparam int P2W = P1W + NW + 1;
    localparam int DW  = (3 * NW + 3 > SQ_W + 2) ? 3 * NW + 3 : SQ_W + 2;
    localparam int SQV_W = 2 * VAL_W;

    // Running state of the current data set.
    logic [NW-1:0]    count_reg, count_next;
    logic             pend_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]  sqs_reg, sqs_next;

    // The count is also kept as 3 * third + mod3, so that one factor of
    // n(n+1)(2n+1) can be divided by three without a divider.
    logic [NW-1:0]    third_reg, third_next;
    logic [1:0]       mod3_reg, mod3_next;

    // Accumulation stage: the square is registered before it is added.
    logic [VAL_W-1:0] val_reg;
    logic [SQV_W-1:0] sqv_reg;

    logic [P1W-1:0]       prod1_reg;
    logic [P1W-1:0]       part_reg;
    logic [P2W-1:0]       prod2_reg;
    logic signed [DW-1:0] diff_reg;
    logic signed [DW-1:0] dsq_reg;
    logic signed [DW-1:0] add_reg;
    out_item_t            result_reg;

    logic [NW:0]          cnt_plus1;
    logic [NW:0]          two_n_plus1;
    logic [NW-1:0]        fac_a;
    logic [NW:0]          fac_b;
    logic [NW:0]          fac_c;
    logic signed [DW-1:0] div_q;
    logic                 div_done;
    logic signed [DW:0]   pair_sum;
    logic signed [DW:0]   pair_adj;
    logic [VAL_W-1:0]     rep_low;

    always_comb
    begin
        count_next = count_reg;
        third_next = third_reg;
        mod3_next  = mod3_reg;
        sum_next   = sum_reg;
        sqs_next   = sqs_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            third_next = '0;
            mod3_next  = '0;
            sum_next   = '0;
            sqs_next   = '0;
        end
        else
        begin
            if (accept && (count_reg < NW'(MAX_COUNT)))
            begin
                count_next = count_reg + 1'b1;
                if (mod3_reg == 2'd2)
                begin
                    mod3_next  = 2'd0;
                    third_next = third_reg + 1'b1;
                end
                else
                begin
                    mod3_next = mod3_reg + 1'b1;
                end
            end
            if (pend_reg)
            begin
                sum_next = sum_reg + SUM_W'(val_reg);
                sqs_next = sqs_reg + SQ_W'(sqv_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            third_reg <= '0;
            mod3_reg  <= '0;
            pend_reg  <= 1'b0;
            sum_reg   <= '0;
            sqs_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            third_reg <= third_next;
            mod3_reg  <= mod3_next;
            pend_reg  <= accept;
            sum_reg   <= sum_next;
            sqs_reg   <= sqs_next;
        end
    end

    assign cnt_plus1   = {1'b0, count_reg} + 1'b1;
    assign two_n_plus1 = {count_reg, 1'b1};

    // Exactly one of n, n + 1 and 2n + 1 is a multiple of three; that factor is
    // replaced by its third, so the product of the three is n(n+1)(2n+1)/3.
    always_comb
    begin
        fac_a = count_reg;
        fac_b = cnt_plus1;
        fac_c = two_n_plus1;
        case (mod3_reg)
            2'd0:
            begin
                fac_a = third_reg;
            end
            2'd1:
            begin
                fac_c = {third_reg, 1'b1};
            end
            2'd2:
            begin
                fac_b = {1'b0, third_reg} + 1'b1;
            end
            default:
            begin
                fac_a = count_reg;
            end
        endcase
    end

    dmf_divider #(
        .DW(DW)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend(dsq_reg),
        .divisor (diff_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    // Halving toward zero: add one to a negative sum before the shift.
    assign pair_sum = {diff_reg[DW-1], diff_reg} + {add_reg[DW-1], add_reg};
    assign pair_adj = pair_sum + $signed((DW + 1)'(pair_sum[DW]));
    assign rep_low  = pair_adj[VAL_W:1];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg <= item.value;
            sqv_reg <= SQV_W'(item.value) * SQV_W'(item.value);
        end
        if (cmd.prod1)
        begin
            prod1_reg <= P1W'(count_reg) * P1W'(cnt_plus1);
            part_reg  <= P1W'(fac_a) * P1W'(fac_b);
        end
        if (cmd.prod2)
        begin
            prod2_reg <= P2W'(part_reg) * P2W'(fac_c);
            diff_reg  <= $signed(DW'(sum_reg)) - $signed(DW'(prod1_reg >> 1));
        end
        if (cmd.load_s2n)
        begin
            // n(n+1)(2n+1)/3 is even, so the shift gives the square sum exactly.
            dsq_reg <= $signed(DW'(sqs_reg)) - $signed(DW'(prod2_reg >> 1));
        end
        if (cmd.load_add)
        begin
            add_reg <= div_q;
        end
        if (cmd.fix)
        begin
            if (diff_reg == '0)
            begin
                result_reg <= '0;
            end
            else
            begin
                result_reg.repeating <= rep_low;
                result_reg.absent    <= rep_low - diff_reg[VAL_W-1:0];
                result_reg.valid_res <= 1'b1;
            end
        end
    end

    assign status.div_done  = div_done;
    assign status.diff_zero = (diff_reg == '0);
    assign result           = result_reg;

endmodule

// ----- hw/rtl/dmf_ctrl.sv -----
// Controller of the duplicate and missing finder: sequences the end-of-set work.
// Depends on dmf_pkg for the command and status structs.
module dmf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 is_last,
    input  dmf_pkg::dmf_status_t status,
    output dmf_pkg::dmf_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import dmf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD1,
        ST_PROD2,
        ST_S2N,
        ST_DIV_ADD,
        ST_WAIT_ADD,
        ST_FIX,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_last)
                begin
                    state_next = ST_PROD1;
                end
            end
            ST_PROD1:
            begin
                cmd.prod1  = 1'b1;
                state_next = ST_PROD2;
            end
            ST_PROD2:
            begin
                cmd.prod2  = 1'b1;
                state_next = ST_S2N;
            end
            ST_S2N:
            begin
                cmd.load_s2n = 1'b1;
                state_next   = status.diff_zero ? ST_FIX : ST_DIV_ADD;
            end
            ST_DIV_ADD:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_ADD;
            end
            ST_WAIT_ADD:
            begin
                if (status.div_done)
                begin
                    cmd.load_add = 1'b1;
                    state_next   = ST_FIX;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_EMIT);

endmodule

// ----- hw/rtl/duplicate_and_missing_finder.sv -----
// Top level of the duplicate and missing finder (set mismatch by sum and sum of squares).
// Depends on dmf_pkg, dmf_ctrl, dmf_datapath and duplicate_and_missing_finder_assert.svh.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+--------------------------------------------
//  input    | start, busy        | item   (value, is_last)
//  result   | done (strobe)      | result (repeating, absent, valid_res)
//
// An input transfer happens at a clock edge where start is high and busy is low.
// Items that are not last can follow back to back; the square of each value is
// registered and added in the next cycle.
// The last item of a set holds busy high while the controller runs the products,
// the square-sum difference, the division when the sums differ, the fix-up and the
// emit step; the divider works at DW = max(3*NW + 3, 37) bits, where
// NW = clog2(MAX_COUNT + 1), so DW is 42 for the default MAX_COUNT.
// done is high for exactly one cycle, the last busy cycle, with the result; the
// receiver cannot stall it.
// Reset (rst_n, asynchronous, active low) clears the count, both sums and the controller.
module duplicate_and_missing_finder #(
    parameter int MAX_COUNT = dmf_pkg::MAX_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  dmf_pkg::in_item_t  item,
    output logic               busy,
    output logic               done,
    output dmf_pkg::out_item_t result
);
    import dmf_pkg::*;

`include "duplicate_and_missing_finder_assert.svh"

    logic        accept;
    dmf_cmd_t    cmd;
    dmf_status_t status;

    // An item enters only while the controller is idle.
    assign accept = start && !busy;

    // The controller steps through the end-of-set sequence after a last item.
    dmf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .is_last(item.is_last),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath keeps the running sums and evaluates the closed forms.
    dmf_datapath #(
        .MAX_COUNT(MAX_COUNT)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .item  (item),
        .cmd   (cmd),
        .status(status),
        .result(result)
    );

    // A last item always starts the end-of-set sequence.
    `DMF_ASSERT(a_last_sets_busy, clk, rst_n, accept && item.is_last |=> busy, "last item did not raise busy")
    // A result strobe lasts a single cycle.
    `DMF_ASSERT(a_done_single, clk, rst_n, done |=> !done, "result strobe longer than one cycle")
    // A result comes only out of the busy sequence, never alongside a new transfer.
    `DMF_ASSERT(a_done_busy, clk, rst_n, done |-> busy, "result strobe while idle")
    // A set without mismatch reports zeros.
    `DMF_ASSERT(a_zero_result, clk, rst_n, done && !result.valid_res |-> result.repeating == 0 && result.absent == 0, "nonzero fields with valid_res low")

endmodule

// ----- tb/tb_duplicate_and_missing_finder.sv -----
// Self-checking testbench for the duplicate and missing finder.
// Depends on dmf_pkg and the duplicate_and_missing_finder top level, with the RTL files that the top level needs.
`timescale 1ns / 1ps

module tb_duplicate_and_missing_finder;
    import dmf_pkg::*;

    // SET_LATENCY is the longest time that the last item of a set keeps the block
    // busy with the default MAX_COUNT. The quiet time at the end covers two of those windows.
    localparam int SET_LATENCY = 49;
    localparam int QUIET_CYCLES = 2 * SET_LATENCY + 20;
    localparam int RANDOM_ITEMS = 280;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_item_t  item;
    logic      busy;
    logic      done;
    out_item_t result;

    duplicate_and_missing_finder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog. The slowest correct run is well under a thousand items with idle
    // gaps plus a full division for every set.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Our own copy of the accumulators. The count saturates at MAX_COUNT while
    // both sums keep wrapping at their register widths.
    logic [VAL_W:0]   set_count;
    logic [SUM_W-1:0] set_sum;
    logic [SQ_W-1:0]  set_square_sum;

    // Results that the block owes us, oldest first.
    out_item_t mismatch_queue[$];

    int fault_count;
    int items_sent;

    // Sender pacing: items go out in bursts, and a random gap follows each burst.
    bit pacing_on;
    int burst_left;

    // Values of the set that is being built, sent in order with the last one marked.
    logic [VAL_W-1:0] set_vals[];

    // Adds one accepted item to the running totals. On the last item it works out
    // the repeating and absent values the way the block must, at 64-bit signed
    // width, and queues the expected result.
    task automatic fold_into_set(input logic [VAL_W-1:0] v, input logic last);
        longint    n;
        longint    sn;
        longint    s2n;
        longint    diff;
        longint    dsq;
        longint    rep_plus_abs;
        longint    rep;
        longint    abs_v;
        longint    acc;
        out_item_t r;
        set_sum        = set_sum + SUM_W'(v);
        set_square_sum = set_square_sum + SQ_W'(v) * SQ_W'(v);
        if (set_count < MAX_COUNT_DEF)
            set_count = set_count + 1'b1;
        if (last)
        begin
            n    = longint'(set_count);
            sn   = (n * (n + 1)) / 2;
            s2n  = (n * (n + 1) * (2 * n + 1)) / 6;
            acc  = longint'(set_sum);
            diff = acc - sn;
            acc  = longint'(set_square_sum);
            dsq  = acc - s2n;
            if (diff == 0)
            begin
                // A sum that matches n(n+1)/2 counts as a clean set; the block
                // must not divide and reports nothing found.
                r = '0;
            end
            else
            begin
                // Both divisions truncate toward zero, which is what signed
                // division on longint does.
                rep_plus_abs = dsq / diff;
                rep          = (diff + rep_plus_abs) / 2;
                abs_v        = rep - diff;
                r.repeating  = rep[VAL_W-1:0];
                r.absent     = abs_v[VAL_W-1:0];
                r.valid_res  = 1'b1;
            end
            mismatch_queue.push_back(r);
            set_count      = '0;
            set_sum        = '0;
            set_square_sum = '0;
        end
    endtask

    // Offers one item and waits for the transfer. It is called at a rising edge and
    // returns at the edge that accepted the item, or after the gap that follows it. When
    // the burst has run out it drops start for a random number of cycles, so gaps also
    // fall while the block is busy with a division.
    task automatic send_item(input logic [VAL_W-1:0] v, input logic last);
        start <= 1'b1;
        item  <= in_item_t'{value: v, is_last: last};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        fold_into_set(v, last);
        items_sent++;
        if (pacing_on)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
                burst_left = $urandom_range(0, 24);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Sends the values in set_vals in order, marking the final one as last.
    task automatic send_set();
        foreach (set_vals[i])
            send_item(set_vals[i], i == set_vals.size() - 1);
    endtask

    // Fills set_vals with a shuffled permutation of 1..n.
    task automatic shuffled_permutation(input int n);
        int               j;
        logic [VAL_W-1:0] tmp;
        set_vals = new[n];
        foreach (set_vals[i])
            set_vals[i] = VAL_W'(i + 1);
        for (int i = n - 1; i > 0; i--)
        begin
            j           = $urandom_range(0, i);
            tmp         = set_vals[i];
            set_vals[i] = set_vals[j];
            set_vals[j] = tmp;
        end
    endtask

    // Turns the permutation in set_vals into a proper mismatch: one position takes
    // the value of another, so that value repeats and its own value goes absent.
    task automatic inject_duplicate();
        int lost;
        int copied;
        lost   = $urandom_range(0, set_vals.size() - 1);
        copied = $urandom_range(0, set_vals.size() - 2);
        if (copied >= lost)
            copied++;
        set_vals[lost] = set_vals[copied];
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fault_count++;
        end
    endtask

    // Every done strobe is one result transfer; the receiver cannot refuse it, so
    // each one is compared with the oldest expectation at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (mismatch_queue.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, result.repeating, result.absent, result.valid_res);
                fault_count++;
            end
            else
            begin
                check_field("repeating", int'(mismatch_queue[0].repeating),
                            int'(result.repeating));
                check_field("absent", int'(mismatch_queue[0].absent), int'(result.absent));
                check_field("valid_res", int'(mismatch_queue[0].valid_res),
                            int'(result.valid_res));
                void'(mismatch_queue.pop_front());
            end
        end
    end

    // Small hand-picked sets: the shortest sets, clean permutations, values at both
    // ends of the range 1..4096, and malformed sets where the formulas give garbage
    // that must still come out bit for bit.
    task automatic test_directed();
        // Two-item sets where either value is the repeated one.
        send_item(13'd1, 1'b0);
        send_item(13'd1, 1'b1);
        send_item(13'd2, 1'b0);
        send_item(13'd2, 1'b1);
        // A single item and a clean permutation both have no mismatch.
        send_item(13'd1, 1'b1);
        send_item(13'd3, 1'b0);
        send_item(13'd2, 1'b0);
        send_item(13'd1, 1'b1);
        // An ordinary mismatch: three repeats and two is absent.
        send_item(13'd1, 1'b0);
        send_item(13'd3, 1'b0);
        send_item(13'd3, 1'b0);
        send_item(13'd4, 1'b1);
        // Malformed sets using the largest values.
        send_item(13'd4096, 1'b0);
        send_item(13'd1, 1'b1);
        send_item(13'd4095, 1'b0);
        send_item(13'd4095, 1'b0);
        send_item(13'd3, 1'b1);
        for (int i = 0; i < 4; i++)
            send_item(13'd4096, i == 3);
    endtask

    // Two longer sets: a shuffled 1..160 permutation with a duplicate, and forty
    // items of the top value whose squares dominate the square sum.
    task automatic test_large_sets();
        shuffled_permutation(160);
        inject_duplicate();
        send_set();

        set_vals = new[40];
        foreach (set_vals[i])
            set_vals[i] = 13'd4096;
        send_set();
    endtask

    // Mostly well-formed sets with one duplicate, so the division path sees real
    // data. Some are clean permutations, and the rest is noise: random lengths of
    // random values from 1 to 4096.
    task automatic test_random_sets();
        int first;
        int kind;
        int n;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(17, 64);
            else
                n = $urandom_range(2, 16);
            if (kind < 7)
            begin
                shuffled_permutation(n);
                inject_duplicate();
            end
            else if (kind == 7)
            begin
                shuffled_permutation(n);
            end
            else
            begin
                set_vals = new[$urandom_range(1, 12)];
                foreach (set_vals[i])
                    set_vals[i] = VAL_W'($urandom_range(1, 4096));
            end
            send_set();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        set_count      = '0;
        set_sum        = '0;
        set_square_sum = '0;
        fault_count    = 0;
        items_sent     = 0;
        pacing_on      = 1'b0;
        burst_left     = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed and large sets run back to back with no idle cycles; the
        // random part then uses bursts and gaps.
        test_directed();
        test_large_sets();
        pacing_on = 1'b1;
        test_random_sets();
        start <= 1'b0;

        while (mismatch_queue.size() != 0)
            @(posedge clk);
        // Give a stray result time to show up after the last expected one.
        repeat (QUIET_CYCLES)
            @(posedge clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/dmf_pkg.sv
hw/rtl/dmf_divider.sv
hw/rtl/dmf_datapath.sv
hw/rtl/dmf_ctrl.sv
hw/rtl/duplicate_and_missing_finder.sv
tb/tb_duplicate_and_missing_finder.sv
